// ===== rtl/core/chst_pkg.sv =====
// Package for the chained hash symbol table core.
// Constants, controller/datapath command and status structs. No dependencies.
package chst_pkg;
  localparam int TableEntries = 256;
  localparam int HashBuckets = 64;
  localparam int NameChars = 16;
  localparam logic [31:0] SeedValue = 32'd271828;
  localparam logic [31:0] MulValue = 32'd314159269;
  localparam logic [31:0] AddValue = 32'd453806245;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusLong = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take_char;   // accept one character
    logic do_mult;     // register product
    logic do_bucket;   // register hash magnitude
    logic do_quot;     // register quotient estimate
    logic do_rem;      // register bucket (remainder)
    logic load_ptr;    // pointer <= head
    logic cmp_start;   // start comparing entry at ptr
    logic cmp_step;    // compare one character
    logic follow_link; // ptr <= link
    logic do_insert;   // write entry
    logic clear_sym;   // back to seed
  } chst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ptr_null;    // pointer is past the table
    logic len_match;   // stored length equals name length
    logic cmp_done;    // all characters compared
    logic char_match;  // current character equal
    logic table_full;
    logic too_long;
    logic copy_busy;   // name store still being written
  } chst_stat_t;
endpackage

// ===== rtl/core/chst_datapath.sv =====
// Datapath: hash, name buffer, table memories, chain walk and compare.
// Depends on chst_pkg.
module chst_datapath #(
  parameter int TABLE_ENTRIES = 256,
  parameter int HASH_BUCKETS = 64,
  parameter int NAME_CHARS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] symbol_char,
  input  chst_pkg::chst_cmd_t cmd,
  output chst_pkg::chst_stat_t stat,
  output logic [7:0] entry_index,
  output logic [7:0] found_index
);
  import chst_pkg::*;
  localparam int EW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int CW = $clog2(NAME_CHARS + 2);
  localparam int KW = $clog2(NAME_CHARS);
  localparam int NW = IW + KW;
  localparam logic [EW-1:0] NullPtr = EW'(TABLE_ENTRIES);
  // floor(2^32 / buckets): quotient estimate is exact or one short
  localparam logic [32:0] Recip = 33'((65'd1 << 32) / HASH_BUCKETS);
  localparam logic [31:0] Buckets32 = 32'(HASH_BUCKETS);

  logic [EW-1:0] heads [HASH_BUCKETS];
  logic [HASH_BUCKETS-1:0] head_valid;
  logic [EW-1:0] links [TABLE_ENTRIES];
  logic [7:0] names [TABLE_ENTRIES * (2 ** KW)];
  logic [CW-1:0] lengths [TABLE_ENTRIES];
  logic [7:0] nbuf [NAME_CHARS];

  logic [31:0] running_sum, product;
  logic odd_position;
  logic [CW-1:0] char_count;
  logic [EW-1:0] next_free, ptr;
  logic [BW-1:0] bucket;
  logic [KW:0] k;
  logic [7:0] name_rd;
  logic [EW-1:0] link_rd;
  logic [CW-1:0] len_rd;

  logic [31:0] sum_f, mag, mag_r, qest, qm, rem_full;
  logic [63:0] quot_full;
  assign sum_f = product + AddValue;
  assign mag = sum_f[31] ? (32'd0 - sum_f) : sum_f;
  assign quot_full = 64'(mag_r) * 64'(Recip);
  assign qm = qest * Buckets32;
  assign rem_full = mag_r - qm;

  // hashing and counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_sym) begin
      running_sum <= SeedValue;
      odd_position <= 1'b0;
      char_count <= '0;
    end else if (cmd.take_char) begin
      running_sum <= running_sum +
        (odd_position ? {16'd0, symbol_char, 8'd0} : {24'd0, symbol_char});
      odd_position <= ~odd_position;
      if (char_count <= CW'(NAME_CHARS)) char_count <= char_count + 1'b1;
    end
  end

  // name buffer; bucket by reciprocal multiply and one corrective subtract
  always_ff @(posedge clk) begin
    if (cmd.take_char && char_count < CW'(NAME_CHARS))
      nbuf[char_count[KW-1:0]] <= symbol_char;
    if (cmd.do_mult) product <= running_sum * MulValue;
    if (cmd.do_bucket) mag_r <= mag;
    if (cmd.do_quot) qest <= quot_full[63:32];
    if (cmd.do_rem)
      bucket <= BW'((rem_full >= Buckets32) ? (rem_full - Buckets32) : rem_full);
  end

  // bucket heads with valid bits
  always_ff @(posedge clk) begin
    if (rst) head_valid <= '0;
    else if (cmd.do_insert) head_valid[bucket] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (cmd.do_insert) heads[bucket] <= next_free;
  end

  // pointer and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= '0;
    end else if (cmd.do_insert) begin
      next_free <= next_free + 1'b1;
    end
    if (cmd.load_ptr) begin
      ptr <= head_valid[bucket] ? heads[bucket] : NullPtr;
    end else if (cmd.follow_link) begin
      ptr <= link_rd;
    end
  end

  // entry memories, registered reads
  logic [IW-1:0] pidx;
  logic [IW-1:0] fidx;
  assign pidx = ptr[IW-1:0];
  assign fidx = next_free[IW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      links[fidx] <= head_valid[bucket] ? heads[bucket] : NullPtr;
      lengths[fidx] <= char_count;
    end
    link_rd <= links[pidx];
    len_rd <= lengths[pidx];
  end

  // k sweep for compare reads; the name copy on insert runs one char per cycle on wk
  logic copy_we;
  logic [KW-1:0] kk;
  assign kk = k[KW-1:0];
  assign copy_we = cmd.do_insert;
  always_ff @(posedge clk) begin
    if (cmd.cmp_start) k <= '0;
    else if (cmd.cmp_step) k <= k + 1'b1;
    name_rd <= names[NW'({pidx, (cmd.cmp_start ? KW'(0) : kk)})];
  end

  // name storage write port, driven by a sweep after insert
  logic [KW:0] wk;
  logic wr_on;
  logic [IW-1:0] wentry;
  always_ff @(posedge clk) begin
    if (rst) wr_on <= 1'b0;
    else if (copy_we) begin
      wr_on <= 1'b1;
      wk <= '0;
      wentry <= fidx;
    end else if (wr_on) begin
      if (wk == (KW+1)'(NAME_CHARS - 1)) wr_on <= 1'b0;
      wk <= wk + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (wr_on) names[NW'({wentry, wk[KW-1:0]})] <= nbuf[wk[KW-1:0]];
  end

  assign stat.ptr_null = (ptr >= NullPtr);
  assign stat.len_match = (len_rd == char_count);
  assign stat.cmp_done = (k >= (KW+1)'(char_count)) || (k == (KW+1)'(NAME_CHARS));
  assign stat.char_match = (name_rd == nbuf[kk]);
  assign stat.table_full = (next_free >= NullPtr);
  assign stat.too_long = (char_count > CW'(NAME_CHARS));
  assign stat.copy_busy = wr_on;
  assign entry_index = 8'(next_free);
  assign found_index = 8'(ptr);
endmodule

// ===== rtl/core/chst_ctrl.sv =====
// Controller state machine for the symbol table: sequencing and result strobe.
// Depends on chst_pkg.
module chst_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic last_char,
  input  chst_pkg::chst_stat_t stat,
  input  logic [7:0] ins_index,
  input  logic [7:0] hit_index,
  output chst_pkg::chst_cmd_t cmd,
  output logic busy,
  output logic done,
  output logic [7:0] entry_index,
  output logic newly_added,
  output logic [1:0] status
);
  import chst_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_MULT, S_BUCKET, S_QUOT, S_REM, S_HEAD, S_CHECK, S_LEN, S_RD, S_CMP,
    S_LINK, S_FINISH, S_WAIT
  } state_t;
  state_t state;
  logic accept;
  assign accept = start && !busy;

  always_comb begin
    cmd = '0;
    cmd.take_char = accept;
    cmd.do_mult = (state == S_MULT);
    cmd.do_bucket = (state == S_BUCKET);
    cmd.do_quot = (state == S_QUOT);
    cmd.do_rem = (state == S_REM);
    cmd.load_ptr = (state == S_HEAD);
    cmd.cmp_start = (state == S_CHECK) && !stat.ptr_null;
    cmd.cmp_step = (state == S_CMP) && !stat.cmp_done && stat.char_match;
    cmd.follow_link = (state == S_LINK);
    cmd.do_insert = (state == S_FINISH) && !stat.table_full && !stat.too_long;
    cmd.clear_sym = (state == S_FINISH) || (state == S_CMP && stat.cmp_done);
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (accept && last_char) begin
          state <= S_MULT;
          busy <= 1'b1;
        end
        S_MULT: state <= S_BUCKET;
        S_BUCKET: state <= S_QUOT;
        S_QUOT: state <= S_REM;
        S_REM: state <= S_HEAD;
        S_HEAD: state <= S_CHECK;
        S_CHECK: state <= stat.ptr_null ? S_FINISH : S_LEN;
        S_LEN: state <= stat.len_match ? S_RD : S_LINK;
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (stat.cmp_done) begin
            entry_index <= hit_index;
            newly_added <= 1'b0;
            status <= StatusOk;
            done <= 1'b1;
            state <= S_WAIT;
          end else if (stat.char_match) state <= S_RD;
          else state <= S_LINK;
        end
        S_LINK: state <= S_CHECK;
        S_FINISH: begin
          done <= 1'b1;
          state <= S_WAIT;
          if (stat.table_full) begin
            entry_index <= '0; newly_added <= 1'b0; status <= StatusFull;
          end else if (stat.too_long) begin
            entry_index <= '0; newly_added <= 1'b0; status <= StatusLong;
          end else begin
            entry_index <= ins_index; newly_added <= 1'b1; status <= StatusOk;
          end
        end
        S_WAIT: if (!stat.copy_busy) begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/chained_hash_symbol_table_core.sv =====
// Top level of the chained hash symbol table core.
// Depends on chst_pkg, chst_ctrl and chst_datapath.
// A character is taken when start is high and busy low, one per cycle while
// not last. On the last character the block goes busy: MULT, BUCKET, QUOT and
// REM hash the name and reduce it to a bucket, HEAD reads the bucket head, then
// the chain walk checks each entry's length, follows the link on a mismatch and
// compares an equal-length name character by character. done is raised for one
// cycle with the result; the receiver cannot stall. busy falls the cycle after
// done, or after an insert once the name store is written.
module chained_hash_symbol_table_core #(
  parameter int TABLE_ENTRIES = chst_pkg::TableEntries,
  parameter int HASH_BUCKETS = chst_pkg::HashBuckets,
  parameter int NAME_CHARS = chst_pkg::NameChars
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [7:0] symbol_char,
  input  logic last_char,
  output logic done,
  output logic [7:0] entry_index,
  output logic newly_added,
  output logic [1:0] status
);
  import chst_pkg::*;
  chst_cmd_t cmd;
  chst_stat_t stat;
  logic [7:0] ins_index, hit_index;

  chst_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .HASH_BUCKETS(HASH_BUCKETS),
    .NAME_CHARS(NAME_CHARS)) u_dp (.clk, .rst, .symbol_char, .cmd, .stat,
    .entry_index(ins_index), .found_index(hit_index));

  chst_ctrl u_ctrl (.clk, .rst, .start, .last_char, .stat, .ins_index, .hit_index,
    .cmd, .busy, .done, .entry_index, .newly_added, .status);
endmodule

// ===== tb/tb_chained_hash_symbol_table_core.sv =====
`timescale 1ns / 100ps
// Testbench for the chained hash symbol table core: character requests in,
// insert-or-lookup results checked against an in-bench table predictor.
// Depends on chst_pkg and chained_hash_symbol_table_core.
module tb_chained_hash_symbol_table_core;
  import chst_pkg::*;

  localparam int WatchdogLimit = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic last;
    logic [5:0] gap;
    logic drain; // wait until all results are in before sending
  } char_req_t;

  typedef struct packed {
    logic [7:0] index;
    logic added;
    logic [1:0] stat;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [7:0] symbol_char = 8'd0;
  logic last_char = 1'b0;
  logic busy, done, newly_added;
  logic [7:0] entry_index;
  logic [1:0] status;

  char_req_t pending_chars[$];
  lookup_res_t expected_lookups[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  // predictor state
  int head_of[HashBuckets];
  int link_of[TableEntries];
  byte unsigned name_of[TableEntries][NameChars];
  int len_of[TableEntries];
  int free_entry;
  byte unsigned cur_name[NameChars];
  logic [31:0] hash_sum;
  int cur_len;
  bit odd_pos;

  // names reused during random stimulus
  byte unsigned known_names[$][$];

  chained_hash_symbol_table_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .symbol_char(symbol_char), .last_char(last_char), .done(done),
    .entry_index(entry_index), .newly_added(newly_added), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void table_clear();
    for (int b = 0; b < HashBuckets; b++) head_of[b] = TableEntries;
    free_entry = 0;
    hash_sum = SeedValue;
    cur_len = 0;
    odd_pos = 1'b0;
  endfunction

  // advance the table model by one character; push a result on the last one
  function automatic void table_take_char(logic [7:0] c, logic last);
    logic [31:0] prod, mag;
    int bkt, ptr, steps, hit;
    bit same;
    lookup_res_t r;
    hash_sum = hash_sum + (odd_pos ? {16'd0, c, 8'd0} : {24'd0, c});
    odd_pos = ~odd_pos;
    if (cur_len < NameChars) cur_name[cur_len] = c;
    if (cur_len <= NameChars) cur_len++;
    if (!last) return;
    prod = hash_sum * MulValue + AddValue;
    mag = prod[31] ? -prod : prod;
    bkt = mag % HashBuckets;
    ptr = head_of[bkt];
    hit = -1;
    steps = 0;
    while (ptr < TableEntries && steps < TableEntries && hit < 0) begin
      same = (len_of[ptr] == cur_len);
      for (int k = 0; k < cur_len && k < NameChars && same; k++)
        if (name_of[ptr][k] != cur_name[k]) same = 1'b0;
      if (same) hit = ptr;
      else ptr = link_of[ptr];
      steps++;
    end
    r = '0;
    r.stat = StatusOk;
    if (hit >= 0) r.index = hit[7:0];
    else if (free_entry >= TableEntries) r.stat = StatusFull;
    else if (cur_len > NameChars) r.stat = StatusLong;
    else begin
      for (int k = 0; k < cur_len; k++) name_of[free_entry][k] = cur_name[k];
      len_of[free_entry] = cur_len;
      link_of[free_entry] = head_of[bkt];
      head_of[bkt] = free_entry;
      r.index = free_entry[7:0];
      r.added = 1'b1;
      free_entry++;
    end
    expected_lookups.push_back(r);
    hash_sum = SeedValue;
    cur_len = 0;
    odd_pos = 1'b0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // queue one symbol as character requests
  task automatic queue_symbol(byte unsigned nm[$], bit quiet = 1'b0, bit drain = 1'b0);
    char_req_t q;
    for (int k = 0; k < nm.size(); k++) begin
      q.ch = nm[k];
      q.last = (k == nm.size() - 1);
      q.gap = ($urandom_range(0, 3) == 0 || quiet) ? 6'd0 : 6'($urandom_range(0, 17));
      q.drain = drain && (k == 0);
      pending_chars.push_back(q);
    end
  endtask

  function automatic void rand_name(output byte unsigned nm[$], input int len);
    nm = {};
    for (int k = 0; k < len; k++) nm.push_back(8'($urandom_range(1, 255)));
  endfunction

  // driver: one request per accepted edge, optional gap between them
  int gap_left = 0;
  bit have_req = 1'b0;
  char_req_t cur_req;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        table_take_char(symbol_char, last_char);
      end
      if (!(start && !busy) && have_req) begin
        // holding the current request
      end else if (pending_chars.size() > 0 && gap_left == 0 &&
                   !(pending_chars[0].drain && expected_lookups.size() > 0)) begin
        cur_req = pending_chars.pop_front();
        gap_left = cur_req.gap;
        if (gap_left == 0) begin
          start <= 1'b1;
          symbol_char <= cur_req.ch;
          last_char <= cur_req.last;
          have_req <= 1'b1;
        end else begin
          pending_chars.push_front(cur_req);
          pending_chars[0].gap = 6'd0;
          start <= 1'b0;
          have_req <= 1'b0;
        end
      end else begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
        have_req <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    lookup_res_t w;
    if (!rst) begin
      if (done) begin
        if (expected_lookups.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          w = expected_lookups.pop_front();
          if (entry_index !== w.index) report_mismatch("entry_index", entry_index, w.index);
          if (newly_added !== w.added) report_mismatch("newly_added", newly_added, w.added);
          if (status !== w.stat) report_mismatch("status", status, w.stat);
        end
      end
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    byte unsigned nm[$];
    int pick;
    table_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, repeats, lengths 1, 16, 17 and longer
    nm = {8'd1}; queue_symbol(nm, 1);
    nm = {8'd255}; queue_symbol(nm, 1);
    nm = {8'd1}; queue_symbol(nm, 1);
    nm = {8'hAA, 8'h55}; queue_symbol(nm);
    nm = {8'h55, 8'hAA}; queue_symbol(nm);
    nm = {}; for (int k = 0; k < NameChars; k++) nm.push_back(8'(255 - k));
    queue_symbol(nm, 1);
    queue_symbol(nm);
    nm.push_back(8'd7); queue_symbol(nm, 1);
    for (int k = 0; k < 10; k++) nm.push_back(8'd128);
    queue_symbol(nm);
    nm = {8'hAA, 8'h55}; queue_symbol(nm, 0, 1);
    known_names.push_back('{8'd1});
    known_names.push_back('{8'hAA, 8'h55});

    // random: mostly short fresh names so the table fills, some repeats and
    // the odd overlong name
    for (int s = 0; s < 400; s++) begin
      pick = $urandom_range(0, 39);
      if (pick < 3 && known_names.size() > 0)
        nm = known_names[$urandom_range(0, known_names.size() - 1)];
      else if (pick == 3) rand_name(nm, $urandom_range(NameChars + 1, NameChars + 4));
      else begin
        rand_name(nm, ($urandom_range(0, 31) == 0) ? NameChars : $urandom_range(1, 2));
        known_names.push_back(nm);
      end
      queue_symbol(nm, 0, s == 150);
    end
    stim_done = 1'b1;
    while (pending_chars.size() != 0 || start || expected_lookups.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_lookups.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/chst_pkg.sv
rtl/core/chst_datapath.sv
rtl/core/chst_ctrl.sv
rtl/core/chained_hash_symbol_table_core.sv
tb/tb_chained_hash_symbol_table_core.sv
